>>> hdl/rgb_color_histogram_assert.svh
// Assertion macros used by the histogram top level.
`ifndef RGB_COLOR_HISTOGRAM_ASSERT_SVH
`define RGB_COLOR_HISTOGRAM_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define RCH_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("rch: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCH_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("rch: next-cycle check failed");

`else

`define RCH_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define RCH_ASSERT_NEXT(lbl, ck, rstn, ante, cons)

`endif

`endif

>>> hdl/rch_pkg.sv
// Shared constants and codes for the RGB color histogram.
`default_nettype none

package rch_pkg;

	// defaults for the top-level parameters
	localparam int MAX_CELLS_PER_AXIS_DEF = 16;
	localparam int COUNT_BITS_DEF         = 24;

	// channel range and field widths
	localparam int FULL_RANGE   = 'h100;
	localparam int CHANNEL_BITS = 8;
	localparam int MODE_BITS    = 2;
	localparam int BIN_SEL_BITS = 12;
	localparam int OUT_BITS     = 24;
	localparam int REGION_BITS  = 9;
	localparam logic [REGION_BITS-1:0] REGION_RESET = 9'd16;
	localparam logic [REGION_BITS-1:0] REGION_MAX   = 9'(FULL_RANGE);

	// fixed-point reciprocal: q = (v * ceil(2^RECIP_SHIFT / r)) >> RECIP_SHIFT
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_BITS  = RECIP_SHIFT + 1;
	localparam int PROD_BITS   = CHANNEL_BITS + RECIP_BITS;

	// stream payload widths
	localparam int S_TDATA_BITS = 40;
	localparam int M_TDATA_BITS = 48;

	// APB
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic [APB_ADDR_BITS-1:0] REG_ADDR_DIVIDE_REGION = 3'd0;

	// item kinds carried on tuser
	localparam logic [MODE_BITS-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd2;

endpackage

`default_nettype wire

>>> hdl/rgb_color_histogram.sv
// RGB color histogram: a quantized 3-D color histogram kept in one counter RAM.
// Each add item divides red, green and blue by the region size (clamped to
// 256/MAX_CELLS_PER_AXIS .. 256), forms the cell (r*dim + g)*dim + b with dim the cells
// per axis, and bumps that cell and the pixel total, both saturating. One item is in
// work at a time: an add item passes three quantize stages, a RAM read and a write
// back, a read item a RAM read plus any wait for the output register, and a mode 3
// item is accepted and ignored. A clear item, reset and every register write run a
// clearing pass over the counter RAM of MAX_CELLS_PER_AXIS**3 cells (4096 at the
// default) during which no item is taken; a register write also reloads the region reciprocal.
// Reads of cells at or past the store depth return zero; counts wider than 24 bits
// are clipped to 24 on the output.
`default_nettype none

`include "rgb_color_histogram_assert.svh"

module rgb_color_histogram #(
	parameter int MAX_CELLS_PER_AXIS = rch_pkg::MAX_CELLS_PER_AXIS_DEF,
	parameter int COUNT_BITS = rch_pkg::COUNT_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// APB configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [rch_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  wire logic [rch_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic      [rch_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                     pready,
	// input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// red[7:0], green[15:8], blue[23:16], bin_select[35:24], zero fill [39:36]
	input  wire logic [rch_pkg::S_TDATA_BITS-1:0]    s_tdata,
	// mode[1:0]
	input  wire logic [rch_pkg::MODE_BITS-1:0]       s_tuser,
	// result stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// bin_count[23:0], pixel_total[47:24]
	output logic      [rch_pkg::M_TDATA_BITS-1:0]    m_tdata
);

	import rch_pkg::*;

	localparam int STORE_DEPTH = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
	localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int AXIS_BITS   = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
	localparam int DIM_BITS    = $clog2(MAX_CELLS_PER_AXIS + 1);
	localparam int MIN_REGION  = (FULL_RANGE + MAX_CELLS_PER_AXIS - 1) / MAX_CELLS_PER_AXIS;
	localparam int EFF_RESET   = (int'(REGION_RESET) < MIN_REGION) ? MIN_REGION :
	                             (int'(REGION_RESET) > FULL_RANGE) ? FULL_RANGE :
	                             int'(REGION_RESET);
	localparam logic [RECIP_BITS-1:0] RECIP_RESET =
		RECIP_BITS'((2 ** RECIP_SHIFT + EFF_RESET - 1) / EFF_RESET);
	localparam logic [DIM_BITS-1:0] DIM_RESET =
		DIM_BITS'((FULL_RANGE + EFF_RESET - 1) / EFF_RESET);
	localparam int SEL_BITS = ((ADDR_BITS > BIN_SEL_BITS) ? ADDR_BITS : BIN_SEL_BITS) + 1;
	localparam logic [ADDR_BITS-1:0] CLR_LAST = ADDR_BITS'(STORE_DEPTH - 1);
	localparam logic [31:0] OUT_MAX = 32'((2 ** OUT_BITS) - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QUANT,
		ST_INC,
		ST_READ
	} state_t;

	state_t                  state_q;
	logic [ADDR_BITS-1:0]    clr_cnt_q;
	logic [ADDR_BITS-1:0]    addr_q;
	logic                    sel_ok_q;
	logic [COUNT_BITS-1:0]   pix_q;
	logic                    out_valid_q;
	logic [M_TDATA_BITS-1:0] out_data_q;
	logic [REGION_BITS-1:0]  region_q;

	logic                    cfg_wr;
	logic                    in_xfer;
	logic [MODE_BITS-1:0]    mode;
	logic [CHANNEL_BITS-1:0] red, green, blue;
	logic [BIN_SEL_BITS-1:0] bin_select;
	logic [SEL_BITS-1:0]     sel_ext;
	logic                    sel_ok;
	logic                    out_free;
	logic                    out_load;

	logic                    recip_busy;
	logic [RECIP_BITS-1:0]   recip;
	logic [DIM_BITS-1:0]     dim;
	logic                    quant_done;
	logic [ADDR_BITS-1:0]    quant_idx;

	logic                    ram_we, ram_re;
	logic [ADDR_BITS-1:0]    ram_waddr, ram_raddr;
	logic [COUNT_BITS-1:0]   ram_wdata, ram_rdata;

	logic [COUNT_BITS-1:0]   bin_inc, pix_inc;
	logic [31:0]             cnt_ext, pix_ext;
	logic [OUT_BITS-1:0]     bin_out, pix_out;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr == REG_ADDR_DIVIDE_REGION);
	assign prdata = (paddr == REG_ADDR_DIVIDE_REGION) ? APB_DATA_BITS'(region_q) : '0;

	// input fields
	assign mode       = s_tuser;
	assign red        = s_tdata[7:0];
	assign green      = s_tdata[15:8];
	assign blue       = s_tdata[23:16];
	assign bin_select = s_tdata[35:24];
	assign sel_ext    = SEL_BITS'(bin_select);
	assign sel_ok     = sel_ext < SEL_BITS'(STORE_DEPTH);

	assign s_tready = (state_q == ST_IDLE) & ~recip_busy;
	assign in_xfer  = s_tvalid & s_tready;
	assign out_free = ~out_valid_q | m_tready;
	assign out_load = (state_q == ST_READ) & out_free & ~cfg_wr;

	rch_recip #(
		.MIN_REGION (MIN_REGION),
		.DIM_BITS   (DIM_BITS),
		.RECIP_RESET(RECIP_RESET),
		.DIM_RESET  (DIM_RESET)
	) u_recip (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cfg_wr),
		.region(pwdata[REGION_BITS-1:0]),
		.busy  (recip_busy),
		.recip (recip),
		.dim   (dim)
	);

	rch_quant #(
		.AXIS_BITS(AXIS_BITS),
		.DIM_BITS (DIM_BITS),
		.IDX_BITS (ADDR_BITS)
	) u_quant (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_xfer && (mode == MODE_ADD)),
		.red   (red),
		.green (green),
		.blue  (blue),
		.recip (recip),
		.dim   (dim),
		.done  (quant_done),
		.idx   (quant_idx)
	);

	// saturating increments
	assign bin_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
	assign pix_inc = (pix_q == '1) ? pix_q : pix_q + COUNT_BITS'(1);

	// counter RAM: the clearing pass and the write back share the write port
	assign ram_we    = (state_q == ST_CLEAR) | (state_q == ST_INC);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : addr_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : bin_inc;
	assign ram_re    = (in_xfer && (mode == MODE_READ)) || ((state_q == ST_QUANT) && quant_done);
	assign ram_raddr = (state_q == ST_QUANT) ? quant_idx : sel_ext[ADDR_BITS-1:0];

	rch_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(STORE_DEPTH)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read results, clipped to the 24-bit output fields
	assign cnt_ext = sel_ok_q ? 32'(ram_rdata) : 32'd0;
	assign pix_ext = 32'(pix_q);
	assign bin_out = (cnt_ext > OUT_MAX) ? OUT_BITS'(OUT_MAX) : cnt_ext[OUT_BITS-1:0];
	assign pix_out = (pix_ext > OUT_MAX) ? OUT_BITS'(OUT_MAX) : pix_ext[OUT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			addr_q      <= '0;
			sel_ok_q    <= 1'b0;
			pix_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			region_q    <= REGION_RESET;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				// a new region invalidates every cell
				region_q  <= pwdata[REGION_BITS-1:0];
				state_q   <= ST_CLEAR;
				clr_cnt_q <= '0;
				pix_q     <= '0;
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						clr_cnt_q <= clr_cnt_q + ADDR_BITS'(1);
						if (clr_cnt_q == CLR_LAST) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (in_xfer) begin
							case (mode)
								MODE_ADD: begin
									state_q <= ST_QUANT;
								end
								MODE_READ: begin
									sel_ok_q <= sel_ok;
									state_q  <= ST_READ;
								end
								MODE_CLEAR: begin
									clr_cnt_q <= '0;
									pix_q     <= '0;
									state_q   <= ST_CLEAR;
								end
								default: begin
								end
							endcase
						end
					end
					ST_QUANT: begin
						if (quant_done) begin
							addr_q  <= quant_idx;
							state_q <= ST_INC;
						end
					end
					ST_INC: begin
						pix_q   <= pix_inc;
						state_q <= ST_IDLE;
					end
					ST_READ: begin
						if (out_free) begin
							out_data_q <= {pix_out, bin_out};
							state_q    <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// the quantized cell always lands inside the counter RAM
	`RCH_ASSERT_IMP(a_idx_in_store, clk, arst_n, quant_done,
		({1'b0, quant_idx} < (ADDR_BITS + 1)'(STORE_DEPTH)))
	// the pixel total only moves on a write back or when a clear starts
	`RCH_ASSERT_NEXT(a_pix_hold_idle, clk, arst_n, (state_q == ST_IDLE),
		($stable(pix_q) || (state_q == ST_CLEAR)))
	// a read result with a free output register shows up on the next cycle
	`RCH_ASSERT_NEXT(a_read_delivers, clk, arst_n,
		((state_q == ST_READ) && !out_valid_q && !cfg_wr), m_tvalid)
	// no item is taken while the region reciprocal is being rebuilt
	`RCH_ASSERT_IMP(a_no_take_recip, clk, arst_n, recip_busy, !in_xfer)

endmodule

`default_nettype wire

>>> hdl/rch_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rch_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096,
	parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [ADDR_BITS-1:0] raddr,
	output logic      [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/rch_recip.sv
// Iterative reciprocal of the region size and the resulting cells per axis.
`default_nettype none

module rch_recip #(
	parameter int MIN_REGION = 16,
	parameter int DIM_BITS = 5,
	parameter logic [rch_pkg::RECIP_BITS-1:0] RECIP_RESET = 17'd4096,
	parameter logic [DIM_BITS-1:0] DIM_RESET = 5'd16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [rch_pkg::REGION_BITS-1:0]    region,
	output logic                                    busy,
	output logic      [rch_pkg::RECIP_BITS-1:0]     recip,
	output logic      [DIM_BITS-1:0]                dim
);

	import rch_pkg::*;

	localparam int CNT_BITS = $clog2(RECIP_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(RECIP_BITS - 1);
	localparam logic [REGION_BITS-1:0] REGION_MIN = REGION_BITS'(MIN_REGION);

	typedef enum logic [1:0] {
		RS_IDLE,
		RS_DIV,
		RS_DIM
	} rstate_t;

	rstate_t                st_q;
	logic [REGION_BITS-1:0] div_q;
	logic [RECIP_BITS-1:0]  num_q;
	logic [REGION_BITS-1:0] rem_q;
	logic [RECIP_BITS-1:0]  quo_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [RECIP_BITS-1:0]  recip_q;
	logic [DIM_BITS-1:0]    dim_q;

	logic [REGION_BITS-1:0] r_eff;
	logic [REGION_BITS:0]   trial;
	logic                   ge;
	logic [REGION_BITS:0]   trial_sub;
	logic [PROD_BITS-1:0]   prod;

	// small regions clamp up, anything past full range quantizes to a single cell
	assign r_eff = (region < REGION_MIN) ? REGION_MIN :
	               (region > REGION_MAX) ? REGION_MAX : region;

	// one restoring-division bit per cycle
	assign trial     = {rem_q, num_q[RECIP_BITS-1]};
	assign ge        = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};

	// cells per axis = floor(255 / r) + 1, exact through the reciprocal
	assign prod = PROD_BITS'(FULL_RANGE - 1) * PROD_BITS'(recip_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= RS_IDLE;
			div_q   <= '0;
			num_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			recip_q <= RECIP_RESET;
			dim_q   <= DIM_RESET;
		end else if (start) begin
			st_q  <= RS_DIV;
			div_q <= r_eff;
			// ceil(2^16 / r) as floor((2^16 + r - 1) / r)
			num_q <= RECIP_BITS'(2 ** RECIP_SHIFT) + RECIP_BITS'(r_eff) - RECIP_BITS'(1);
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				RS_IDLE: begin
				end
				RS_DIV: begin
					rem_q <= ge ? trial_sub[REGION_BITS-1:0] : trial[REGION_BITS-1:0];
					quo_q <= {quo_q[RECIP_BITS-2:0], ge};
					num_q <= {num_q[RECIP_BITS-2:0], 1'b0};
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (cnt_q == CNT_LAST) begin
						recip_q <= {quo_q[RECIP_BITS-2:0], ge};
						st_q    <= RS_DIM;
					end
				end
				RS_DIM: begin
					dim_q <= DIM_BITS'(prod[RECIP_SHIFT +: REGION_BITS] + REGION_BITS'(1));
					st_q  <= RS_IDLE;
				end
				default: begin
					st_q <= RS_IDLE;
				end
			endcase
		end
	end

	assign busy  = st_q != RS_IDLE;
	assign recip = recip_q;
	assign dim   = dim_q;

endmodule

`default_nettype wire

>>> hdl/rch_quant.sv
// Three-stage pipeline from an RGB pixel to its histogram cell address.
`default_nettype none

module rch_quant #(
	parameter int AXIS_BITS = 4,
	parameter int DIM_BITS = 5,
	parameter int IDX_BITS = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [rch_pkg::CHANNEL_BITS-1:0]    red,
	input  wire logic [rch_pkg::CHANNEL_BITS-1:0]    green,
	input  wire logic [rch_pkg::CHANNEL_BITS-1:0]    blue,
	input  wire logic [rch_pkg::RECIP_BITS-1:0]      recip,
	input  wire logic [DIM_BITS-1:0]                 dim,
	output logic                                     done,
	output logic      [IDX_BITS-1:0]                 idx
);

	import rch_pkg::*;

	logic [PROD_BITS-1:0] pr, pg, pb;
	logic                 v_s1, v_s2, v_s3;
	logic [AXIS_BITS-1:0] qr_s1, qg_s1, qb_s1;
	logic [AXIS_BITS-1:0] qb_s2;
	logic [IDX_BITS-1:0]  part_s2;
	logic [IDX_BITS-1:0]  idx_s3;

	assign pr = PROD_BITS'(red) * PROD_BITS'(recip);
	assign pg = PROD_BITS'(green) * PROD_BITS'(recip);
	assign pb = PROD_BITS'(blue) * PROD_BITS'(recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// quotients stay below cells per axis, so AXIS_BITS holds them
	always_ff @(posedge clk) begin
		qr_s1   <= pr[RECIP_SHIFT +: AXIS_BITS];
		qg_s1   <= pg[RECIP_SHIFT +: AXIS_BITS];
		qb_s1   <= pb[RECIP_SHIFT +: AXIS_BITS];
		part_s2 <= IDX_BITS'(qr_s1) * IDX_BITS'(dim) + IDX_BITS'(qg_s1);
		qb_s2   <= qb_s1;
		idx_s3  <= part_s2 * IDX_BITS'(dim) + IDX_BITS'(qb_s2);
	end

	assign done = v_s3;
	assign idx  = idx_s3;

endmodule

`default_nettype wire

>>> bench/rch_checker.sv
// Scoreboard for the RGB color histogram: tracks the bins, predicts each read, checks the results.
`timescale 1ns / 1ps

module rch_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic                               pready,
	input  logic [rch_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [rch_pkg::APB_DATA_BITS-1:0]  pwdata,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [rch_pkg::S_TDATA_BITS-1:0]   s_tdata,
	input  logic [rch_pkg::MODE_BITS-1:0]      s_tuser,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [rch_pkg::M_TDATA_BITS-1:0]   m_tdata,
	output int                                 mismatches,
	output int                                 pending
);
	import rch_pkg::*;

	localparam int CELLS = MAX_CELLS_PER_AXIS_DEF ** 3;
	localparam int REGION_FLOOR = (FULL_RANGE + MAX_CELLS_PER_AXIS_DEF - 1) / MAX_CELLS_PER_AXIS_DEF;
	localparam logic [COUNT_BITS_DEF-1:0] COUNT_TOP = '1;
	localparam logic [OUT_BITS-1:0] OUT_TOP = '1;

	// packed so that it lines up with m_tdata: pixel_total high, bin_count low
	typedef struct packed {
		logic [OUT_BITS-1:0] pixel_total;
		logic [OUT_BITS-1:0] bin_count;
	} hist_reading_t;

	logic [COUNT_BITS_DEF-1:0] cell_count [CELLS];
	logic [COUNT_BITS_DEF-1:0] pixels_added;
	logic [REGION_BITS-1:0]    region_step;
	hist_reading_t             readings_due [$];
	int                        fail_count = 0;

	function automatic logic [COUNT_BITS_DEF-1:0] bump(logic [COUNT_BITS_DEF-1:0] v);
		return (v == COUNT_TOP) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_BITS-1:0] clip(logic [COUNT_BITS_DEF-1:0] v);
		return (v > OUT_TOP) ? OUT_TOP : OUT_BITS'(v);
	endfunction

	function automatic int cell_index(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [REGION_BITS-1:0] region);
		int step;
		int dim;
		// regions below the floor act as the floor
		step = (region < REGION_FLOOR) ? REGION_FLOOR : int'(region);
		dim = (FULL_RANGE + step - 1) / step;
		return ((int'(r) / step) * dim + int'(g) / step) * dim + int'(b) / step;
	endfunction

	task automatic wipe();
		for (int i = 0; i < CELLS; i++)
			cell_count[i] = '0;
		pixels_added = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		hist_reading_t seen;
		hist_reading_t want;
		int bin_idx;
		int sel;
		if (!arst_n) begin
			wipe();
			region_step = REGION_RESET;
			readings_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata;
				if (readings_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t unexpected result transfer: bin_count %0d pixel_total %0d",
							$realtime, seen.bin_count, seen.pixel_total);
				end else begin
					want = readings_due.pop_front();
					if (seen.bin_count !== want.bin_count ||
							seen.pixel_total !== want.pixel_total) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%t mismatch: bin_count exp %0d got %0d, pixel_total exp %0d got %0d",
								$realtime, want.bin_count, seen.bin_count,
								want.pixel_total, seen.pixel_total);
					end
				end
			end

			// a region write also clears the histogram
			if (psel && penable && pwrite && pready && paddr == REG_ADDR_DIVIDE_REGION) begin
				region_step = pwdata[REGION_BITS-1:0];
				wipe();
			end

			if (s_tvalid && s_tready) begin
				case (s_tuser)
					MODE_ADD: begin
						bin_idx = cell_index(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
							region_step);
						if (bin_idx < CELLS)
							cell_count[bin_idx] = bump(cell_count[bin_idx]);
						pixels_added = bump(pixels_added);
					end
					MODE_READ: begin
						sel = int'(s_tdata[35:24]);
						want.bin_count = (sel < CELLS) ? clip(cell_count[sel]) : '0;
						want.pixel_total = clip(pixels_added);
						readings_due = {readings_due, want};
					end
					MODE_CLEAR: wipe();
					default: ;
				endcase
			end
		end
		pending <= readings_due.size();
		mismatches <= fail_count;
	end

endmodule

>>> bench/testbench.sv
// Top-level bench for the RGB color histogram: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
	import rch_pkg::*;

	localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
	localparam int REGION_FLOOR = (FULL_RANGE + MAX_CELLS_PER_AXIS_DEF - 1) / MAX_CELLS_PER_AXIS_DEF;
	localparam int PHASE_ITEMS = 133;
	localparam int SETTLE_CYCLES = 16;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_BITS-1:0]  paddr;
	logic [APB_DATA_BITS-1:0]  pwdata;
	logic [APB_DATA_BITS-1:0]  prdata;
	logic                      pready;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [S_TDATA_BITS-1:0]   s_tdata;   // red[7:0], green[15:8], blue[23:16], bin_select[35:24]
	logic [MODE_BITS-1:0]      s_tuser;   // mode[1:0]
	logic                      m_tvalid;
	logic                      m_tready;
	logic [M_TDATA_BITS-1:0]   m_tdata;   // bin_count[23:0], pixel_total[47:24]

	int mismatches;
	int pending;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	logic [REGION_BITS-1:0] region_now;
	logic [7:0]  last_r, last_g, last_b;
	logic [23:0] palette [8];
	logic [REGION_BITS-1:0] region_plan [9] =
		'{9'd0, 9'd256, 9'd511, 9'd37, 9'd17, 9'd128, 9'd255, 9'd16, 9'd100};

	rgb_color_histogram u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	rch_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[rgb_color_histogram] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// cell a pixel lands in under the current region, used to aim reads at live bins
	function automatic logic [11:0] cell_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int step;
		int dim;
		step = (region_now < REGION_FLOOR) ? REGION_FLOOR : int'(region_now);
		dim = (FULL_RANGE + step - 1) / step;
		return 12'(((int'(r) / step) * dim + int'(g) / step) * dim + int'(b) / step);
	endfunction

	task automatic send_item(input logic [MODE_BITS-1:0] mode, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [11:0] sel);
		if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {4'b0, sel, b, g, r};
		do @(posedge clk); while (!s_tready);
		if (mode == MODE_ADD) begin
			last_r = r;
			last_g = g;
			last_b = b;
		end
	endtask

	// hold off until every predicted result has been seen, then let the pipe settle
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_region(input logic [REGION_BITS-1:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= REG_ADDR_DIVIDE_REGION;
		pwdata  <= APB_DATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		region_now = value;
	endtask

	task automatic pick_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			{r, g, b} = {last_r, last_g, last_b};   // repeats the last added pixel, so its bin is hit again
		else if (roll < 65)
			{r, g, b} = palette[$urandom_range(0, 7)];
		else if (roll < 75) begin
			r = $urandom_range(0, 1) ? 8'hff : 8'h00;
			g = $urandom_range(0, 1) ? 8'hff : 8'h00;
			b = $urandom_range(0, 1) ? 8'hff : 8'h00;
		end else
			{r, g, b} = 24'($urandom);
	endtask

	initial begin
		logic [7:0]  r, g, b;
		logic [11:0] sel;
		int roll;
		int made;

		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= MODE_ADD;
		m_tready <= 1'b0;
		region_now = REGION_RESET;
		{last_r, last_g, last_b} = '0;
		foreach (palette[i])
			palette[i] = 24'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty read, channel extremes, repeated bin, unused mode, clear
		send_item(MODE_READ,   8'h00, 8'h00, 8'h00, 12'd0);
		send_item(MODE_ADD,    8'h00, 8'h00, 8'h00, 12'hfff);
		send_item(MODE_ADD,    8'hff, 8'hff, 8'hff, 12'h000);
		send_item(MODE_ADD,    8'hff, 8'h00, 8'h80, 12'h000);
		send_item(MODE_ADD,    8'hff, 8'hff, 8'hff, 12'h000);
		send_item(MODE_ADD,    8'hff, 8'hff, 8'hff, 12'h000);
		send_item(MODE_READ,   8'hff, 8'hff, 8'hff, 12'd0);
		send_item(MODE_READ,   8'h00, 8'h00, 8'h00, 12'hfff);
		send_item(MODE_READ,   8'h00, 8'h00, 8'h00, cell_of(8'hff, 8'h00, 8'h80));
		send_item(MODE_UNUSED, 8'hff, 8'hff, 8'hff, 12'hfff);
		send_item(MODE_READ,   8'h00, 8'h00, 8'h00, 12'hfff);
		send_item(MODE_CLEAR,  8'h00, 8'h00, 8'h00, 12'h000);
		send_item(MODE_READ,   8'h00, 8'h00, 8'h00, 12'hfff);
		send_item(MODE_ADD,    8'd15, 8'd16, 8'd31, 12'h000);
		send_item(MODE_ADD,    8'd16, 8'd15, 8'd240, 12'h000);
		send_item(MODE_READ,   8'h00, 8'h00, 8'h00, cell_of(8'd15, 8'd16, 8'd31));
		send_item(MODE_READ,   8'h00, 8'h00, 8'h00, cell_of(8'd16, 8'd15, 8'd240));
		drain();

		region_plan[8] = 9'($urandom_range(16, 300));
		foreach (region_plan[p]) begin
			case (p % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
				default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
			endcase
			write_region(region_plan[p]);
			foreach (palette[i])
				palette[i] = 24'($urandom);
			made = 0;
			while (made < PHASE_ITEMS) begin
				roll = $urandom_range(0, 999);
				if (roll < 700) begin
					pick_pixel(r, g, b);
					send_item(MODE_ADD, r, g, b, 12'($urandom));
					made++;
				end else if (roll < 960) begin
					if ($urandom_range(0, 9) < 6) begin
						pick_pixel(r, g, b);
						sel = cell_of(r, g, b);
					end else
						sel = 12'($urandom_range(0, 4095));
					{r, g, b} = 24'($urandom);
					send_item(MODE_READ, r, g, b, sel);
					made++;
				end else if (roll < 985) begin
					{r, g, b} = 24'($urandom);
					send_item(MODE_UNUSED, r, g, b, 12'($urandom));
				end else begin
					{r, g, b} = 24'($urandom);
					send_item(MODE_CLEAR, r, g, b, 12'($urandom));
					made++;
				end
			end
			// closing read: its result means everything before it has retired
			send_item(MODE_READ, 8'h00, 8'h00, 8'h00, cell_of(last_r, last_g, last_b));
			drain();
		end

		repeat (32) @(posedge clk);
		if (mismatches == 0)
			$display("[rgb_color_histogram] OK");
		else
			$display("[rgb_color_histogram] ERROR");
		$finish;
	end

endmodule
